>>> design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	// Field widths
	localparam int WIND_W   = 16;
	localparam int HALF_W   = 15;
	localparam int CNT_W    = 16;
	localparam int AGE_W    = 5;

	// Stream widths (padded to whole bytes)
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	// Default history depth in hours
	localparam int HIST_HOURS_DEF = 24;

	// Timing constants
	localparam logic [CNT_W-1:0] MS_START         = 16'd30000;
	localparam logic [CNT_W-1:0] MS_PER_SEC       = 16'd1000;
	localparam logic [CNT_W-1:0] SEC_PER_HOUR     = 16'd3600;
	localparam logic [CNT_W-1:0] SEC_PER_HALF_DAY = 16'd43200;

	// Shared adder/subtractor
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} alu_req_t;

	// carry on ALU_SUB means a >= b (unsigned)
	typedef struct packed {
		logic [CNT_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage
`default_nettype wire

>>> design/tcw_alu.sv
`default_nettype none
module tcw_alu (
	input  tcw_pkg::alu_req_t req,
	output tcw_pkg::alu_rsp_t rsp
);
	import tcw_pkg::*;

	logic [CNT_W-1:0] b_eff;
	logic             cin;
	logic [CNT_W:0]   full;

	// one 16-bit add; subtract as a + ~b + 1
	always_comb begin
		unique case (req.op)
			ALU_ADD: begin
				b_eff = req.b;
				cin   = 1'b0;
			end
			ALU_SUB: begin
				b_eff = ~req.b;
				cin   = 1'b1;
			end
			default: begin
				b_eff = req.b;
				cin   = 1'b0;
			end
		endcase
		full = {1'b0, req.a} + {1'b0, b_eff} + {{CNT_W{1'b0}}, cin};
	end

	assign rsp.sum   = full[CNT_W-1:0];
	assign rsp.carry = full[CNT_W];

endmodule
`default_nettype wire

>>> design/tcw_hist.sv
`default_nettype none
module tcw_hist #(
	parameter int HISTORY_HOURS = tcw_pkg::HIST_HOURS_DEF,
	parameter int IDX_W         = $clog2(HISTORY_HOURS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift_en,
	input  wire logic [tcw_pkg::WIND_W-1:0] shift_data,
	input  wire logic [IDX_W-1:0]           rd_idx,
	output logic      [tcw_pkg::WIND_W-1:0] rd_data
);
	import tcw_pkg::*;

	logic [WIND_W-1:0] hist_q [HISTORY_HOURS];

	// shift line, newest at entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_HOURS; i++) hist_q[i] <= '0;
		end else if (shift_en) begin
			hist_q[0] <= shift_data;
			for (int i = 1; i < HISTORY_HOURS; i++) hist_q[i] <= hist_q[i-1];
		end
	end

	// scan read port
	assign rd_data = hist_q[rd_idx];

endmodule
`default_nettype wire

>>> design/tick_clock_with_wind_max_history.sv
// Channel   Dir  Fields (from bit 0 up)
// s_axis    in   wind_speed[15:0], pulse_half_period[30:16], pad[31]
// m_axis    out  pulse_level[0], max_wind[16:1], max_wind_hours_ago[21:17],
//                seconds_in_half_day[37:22], half_days[53:38], pad[55:54]
//
// An accepted item runs the ms increment, second check, pulse check (skipped with the
// pulse disabled) and ST_OUT, where the result is loaded. A second boundary adds the
// second increment and wrap and the hour check; a whole hour adds shift and rescan.
// Arithmetic but the index step uses one 16-bit adder/subtractor, one step a cycle.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a result until taken; the next item may already
// be accepted, but its result waits until the register is free.
// Reset (arst_n low) sets ms_q to MS_START; clears other counters, history, tvalid.
`default_nettype none
module tick_clock_with_wind_max_history #(
	parameter int HISTORY_HOURS = tcw_pkg::HIST_HOURS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// wind_speed, pulse_half_period, pad
	input  wire logic [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// pulse_level, max_wind, max_wind_hours_ago, seconds_in_half_day, half_days, pad
	output logic      [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tcw_pkg::*;

	localparam int IDX_W = $clog2(HISTORY_HOURS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_HOURS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INC,
		ST_SEC_DIFF,
		ST_SEC_CMP,
		ST_SEC_INC,
		ST_SEC_WRAP,
		ST_HD_INC,
		ST_HOUR_MOD,
		ST_SHIFT,
		ST_SCAN,
		ST_PULSE_DIFF,
		ST_PULSE_CMP,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  ms_q;
	logic [CNT_W-1:0]  mark_q;
	logic [CNT_W-1:0]  sec_q;
	logic [CNT_W-1:0]  hd_q;
	logic [CNT_W-1:0]  toggle_q;
	logic              pulse_q;
	logic [WIND_W-1:0] hmax_q;
	logic [AGE_W-1:0]  age_q;
	logic [CNT_W-1:0]  diff_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WIND_W-1:0] wind_q;
	logic [HALF_W-1:0] half_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic              shift_en;
	logic [WIND_W-1:0] rd_data;
	logic              in_acc;
	logic              out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign shift_en      = (state_q == ST_SHIFT);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// operand select for the shared unit
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = ms_q;
		alu_req.b  = 16'd1;
		unique case (state_q)
			ST_INC: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ms_q;
				alu_req.b  = 16'd1;
			end
			ST_SEC_DIFF: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ms_q;
				alu_req.b  = mark_q;
			end
			ST_SEC_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = diff_q;
				alu_req.b  = MS_PER_SEC;
			end
			ST_SEC_INC: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = sec_q;
				alu_req.b  = 16'd1;
			end
			ST_SEC_WRAP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = sec_q;
				alu_req.b  = SEC_PER_HALF_DAY;
			end
			ST_HD_INC: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = hd_q;
				alu_req.b  = 16'd1;
			end
			ST_HOUR_MOD: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = rem_q;
				alu_req.b  = SEC_PER_HOUR;
			end
			ST_SCAN: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = hmax_q;
				alu_req.b  = rd_data;
			end
			ST_PULSE_DIFF: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ms_q;
				alu_req.b  = toggle_q;
			end
			ST_PULSE_CMP: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = diff_q;
				alu_req.b  = {1'b0, half_q};
			end
			ST_IDLE, ST_SHIFT, ST_OUT: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ms_q;
				alu_req.b  = 16'd1;
			end
			default: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ms_q;
				alu_req.b  = 16'd1;
			end
		endcase
	end

	tcw_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	tcw_hist #(
		.HISTORY_HOURS (HISTORY_HOURS),
		.IDX_W         (IDX_W)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift_en   (shift_en),
		.shift_data (wind_q),
		.rd_idx     (idx_q),
		.rd_data    (rd_data)
	);

	// input capture, payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wind_q <= s_axis_tdata[WIND_W-1:0];
			half_q <= s_axis_tdata[WIND_W +: HALF_W];
		end
	end

	// sequencer, clock state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ms_q        <= MS_START;
			mark_q      <= '0;
			sec_q       <= '0;
			hd_q        <= '0;
			toggle_q    <= '0;
			pulse_q     <= 1'b0;
			hmax_q      <= '0;
			age_q       <= '0;
			diff_q      <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_INC;
				end
				ST_INC: begin
					ms_q    <= alu_rsp.sum;
					state_q <= ST_SEC_DIFF;
				end
				ST_SEC_DIFF: begin
					diff_q  <= alu_rsp.sum;
					state_q <= ST_SEC_CMP;
				end
				ST_SEC_CMP: begin
					// signed difference reached one second
					if (!diff_q[CNT_W-1] && alu_rsp.carry) begin
						mark_q  <= ms_q;
						state_q <= ST_SEC_INC;
					end else begin
						state_q <= ST_PULSE_DIFF;
					end
				end
				ST_SEC_INC: begin
					sec_q   <= alu_rsp.sum;
					state_q <= ST_SEC_WRAP;
				end
				ST_SEC_WRAP: begin
					if (alu_rsp.carry) begin
						sec_q   <= '0;
						state_q <= ST_HD_INC;
					end else begin
						rem_q   <= sec_q;
						state_q <= ST_HOUR_MOD;
					end
				end
				ST_HD_INC: begin
					hd_q    <= alu_rsp.sum;
					rem_q   <= '0;
					state_q <= ST_HOUR_MOD;
				end
				ST_HOUR_MOD: begin
					// repeated subtraction: zero remainder means a whole hour
					priority if (rem_q == '0) begin
						state_q <= ST_SHIFT;
					end else if (alu_rsp.carry) begin
						rem_q <= alu_rsp.sum;
					end else begin
						state_q <= ST_PULSE_DIFF;
					end
				end
				ST_SHIFT: begin
					hmax_q  <= '0;
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// strict greater wins, so the newest of equal values stays
					if (!alu_rsp.carry) begin
						hmax_q <= rd_data;
						age_q  <= AGE_W'(idx_q);
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_PULSE_DIFF;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_PULSE_DIFF: begin
					if (half_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						diff_q  <= alu_rsp.sum;
						state_q <= ST_PULSE_CMP;
					end
				end
				ST_PULSE_CMP: begin
					if (!diff_q[CNT_W-1] && alu_rsp.carry) begin
						pulse_q  <= ~pulse_q;
						toggle_q <= ms_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, hd_q, sec_q, age_q, hmax_q, pulse_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/tcw_chk.sv
`default_nettype none
module tcw_chk #(
	parameter int HISTORY_HOURS = tcw_pkg::HIST_HOURS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tcw_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// seconds stay inside the half day
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[37:22] < SEC_PER_HALF_DAY)
		else $error("seconds out of range");

	// age of the maximum is a valid history index
	a_age_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (HISTORY_HOURS > 32) || (m_axis_tdata[21:17] < HISTORY_HOURS))
		else $error("maximum age out of range");

	// block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accept");

	// padding bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00)
		else $error("result padding not zero");

endmodule

bind tick_clock_with_wind_max_history tcw_chk #(
	.HISTORY_HOURS (HISTORY_HOURS)
) u_tcw_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
